>>> hw/rtl/lzsd_pkg.sv
`timescale 1ns / 1ps

package lzsd_pkg;

  // Dictionary geometry
  localparam int WinAw          = 12;
  localparam int WinDepth       = 1 << WinAw;
  localparam int FillW          = WinAw + 1;
  localparam logic [WinAw-1:0] WinStart = 12'hFEE;

  // Token geometry
  localparam int LenW           = 5;
  localparam logic [LenW-1:0] MinMatch = 5'd3;
  localparam int CountW         = 24;

  // Token phase of the parser
  typedef enum logic [1:0] {
    PH_FLAG = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  // Command from the parser to the copy engine
  typedef struct packed {
    logic             start;
    logic             literal;
    logic [7:0]       data;
    logic [WinAw-1:0] pos;
    logic [LenW-1:0]  len;
  } copy_cmd_t;

  // Configuration register indexes
  localparam logic REG_OUTPUT_LENGTH = 1'b0;

endpackage

>>> hw/rtl/lzsd_window_ram.sv
`timescale 1ns / 1ps

module lzsd_window_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [lzsd_pkg::WinAw-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [lzsd_pkg::WinAw-1:0] rd_addr,
  output logic [7:0]                rd_data
);
  import lzsd_pkg::*;

  logic [7:0] mem [WinDepth];
  logic [7:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/lzsd_parser.sv
`timescale 1ns / 1ps

module lzsd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          in_byte,
  output lzsd_pkg::copy_cmd_t cmd
);
  import lzsd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] flag_r, flag_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] flag_shifted;

  assign flag_shifted = {1'b0, flag_r[15:1]};

  // Next phase, flag shifter and low byte latch
  always_comb begin
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    low_nxt   = low_r;
    if (take) begin
      case (phase_r)
        PH_LOW: begin
          if (flag_r[0]) begin
            flag_nxt  = flag_shifted;
            phase_nxt = flag_shifted[8] ? PH_LOW : PH_FLAG;
          end else begin
            low_nxt   = in_byte;
            phase_nxt = PH_HIGH;
          end
        end
        PH_HIGH: begin
          flag_nxt  = flag_shifted;
          phase_nxt = flag_shifted[8] ? PH_LOW : PH_FLAG;
        end
        default: begin
          flag_nxt  = {8'hFF, in_byte};
          phase_nxt = PH_LOW;
        end
      endcase
    end
  end

  // Command toward the copy engine
  always_comb begin
    cmd         = '0;
    cmd.data    = in_byte;
    cmd.pos     = {in_byte[3:0], low_r};
    cmd.len     = {1'b0, in_byte[7:4]} + MinMatch;
    cmd.literal = (phase_r == PH_LOW);
    case (phase_r)
      PH_LOW:  cmd.start = take && flag_r[0];
      PH_HIGH: cmd.start = take;
      default: cmd.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAG;
      flag_r  <= '0;
      low_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

>>> hw/rtl/lzsd_copy_engine.sv
`timescale 1ns / 1ps

module lzsd_copy_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lzsd_pkg::copy_cmd_t         cmd,
  input  logic [lzsd_pkg::CountW-1:0] output_length,
  output logic                        busy,
  output logic [lzsd_pkg::CountW-1:0] produced,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_run_last,
  output logic                        out_stream_done
);
  import lzsd_pkg::*;

  logic              active_r, active_nxt;
  logic              pend_r, pend_nxt;
  logic              fwd_r, fwd_nxt;
  logic [7:0]        fwd_data_r, fwd_data_nxt;
  logic              vld_r, vld_nxt;
  logic [WinAw-1:0]  rd_addr_r, rd_addr_nxt;
  logic [LenW-1:0]   rd_left_r, rd_left_nxt;
  logic [LenW-1:0]   rem_r, rem_nxt;
  logic [WinAw-1:0]  wp_r, wp_nxt;
  logic [FillW-1:0]  fill_r, fill_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;

  logic              out_free;
  logic              emit;
  logic              issue;
  logic              last_byte;
  logic              reach;
  logic [CountW-1:0] count_inc;
  logic [7:0]        rd_data;
  logic [7:0]        cur_byte;
  logic [WinAw-1:0]  rd_dist;
  logic              rd_written;

  lzsd_window_ram u_ram (
    .clk     (clk),
    .wr_en   (emit),
    .wr_addr (wp_r),
    .wr_data (cur_byte),
    .rd_en   (issue),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // Byte of the current output: forwarded, read, or never-written zero
  assign cur_byte  = fwd_r ? fwd_data_r : (vld_r ? rd_data : 8'h00);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = active_r && pend_r && out_free;
  assign count_inc = count_r + 1'b1;
  assign reach     = (count_inc == output_length);
  assign last_byte = (rem_r == LenW'(1)) || reach;
  assign issue     = active_r && (rd_left_r != '0) && (!pend_r || emit)
                     && !(emit && last_byte);

  // Entries are written in order from the start position, so a fill count tells
  // which ones have never been written
  assign rd_dist    = rd_addr_r - WinStart;
  assign rd_written = ({1'b0, rd_dist} < fill_r);

  // Advance the copy, write back and load the output register
  always_comb begin
    active_nxt    = active_r;
    pend_nxt      = pend_r;
    fwd_nxt       = fwd_r;
    fwd_data_nxt  = fwd_data_r;
    vld_nxt       = vld_r;
    rd_addr_nxt   = rd_addr_r;
    rd_left_nxt   = rd_left_r;
    rem_nxt       = rem_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;

    if (cmd.start) begin
      active_nxt   = 1'b1;
      fwd_data_nxt = cmd.data;
      rd_addr_nxt  = cmd.pos;
      if (cmd.literal) begin
        pend_nxt    = 1'b1;
        fwd_nxt     = 1'b1;
        rd_left_nxt = '0;
        rem_nxt     = LenW'(1);
      end else begin
        pend_nxt    = 1'b0;
        rd_left_nxt = cmd.len;
        rem_nxt     = cmd.len;
      end
    end else begin
      if (emit) begin
        wp_nxt        = wp_r + 1'b1;
        fill_nxt      = fill_r[FillW-1] ? fill_r : fill_r + 1'b1;
        count_nxt     = count_inc;
        rem_nxt       = rem_r - 1'b1;
        pend_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = cur_byte;
        out_last_nxt  = last_byte;
        out_done_nxt  = reach;
        if (last_byte) begin
          active_nxt  = 1'b0;
          rd_left_nxt = '0;
        end
      end
      if (issue) begin
        pend_nxt     = 1'b1;
        rd_addr_nxt  = rd_addr_r + 1'b1;
        rd_left_nxt  = rd_left_r - 1'b1;
        vld_nxt      = rd_written;
        // Forward the byte written in the same cycle at the read address
        fwd_nxt      = emit && (rd_addr_r == wp_r);
        fwd_data_nxt = cur_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pend_r      <= 1'b0;
      rd_left_r   <= '0;
      rem_r       <= '0;
      wp_r        <= WinStart;
      fill_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pend_r      <= pend_nxt;
      rd_left_r   <= rd_left_nxt;
      rem_r       <= rem_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fwd_r      <= fwd_nxt;
    fwd_data_r <= fwd_data_nxt;
    vld_r      <= vld_nxt;
    rd_addr_r  <= rd_addr_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign busy            = active_r;
  assign produced        = count_r;
  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_last_r;
  assign out_stream_done = out_done_r;

endmodule

>>> hw/rtl/lzss_stream_decoder.sv
// Flag and reference low bytes only update the parser. A literal is registered in the copy
// engine and then in the output register; a reference of N bytes is read byte by byte through
// the registered read port into the output register, one byte per cycle while the output is
// not stalled, through the one read port and one write port of the dictionary memory.
// Reset (synchronous, active low) clears control state; unwritten dictionary entries
// read as zero through a fill count, so the block takes input right after reset.
`timescale 1ns / 1ps

module lzss_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // compressed input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // decompressed output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_stream_done,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lzsd_pkg::*;

  logic [CountW-1:0] out_len_r, out_len_nxt;
  logic [CountW-1:0] produced;
  logic              busy;
  logic              halted;
  logic              in_take;
  logic              cfg_wr;
  copy_cmd_t         cmd;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == REG_OUTPUT_LENGTH);
  assign out_len_nxt = cfg_wr ? cfg_pwdata[CountW-1:0] : out_len_r;
  assign cfg_prdata  = (cfg_paddr[2] == REG_OUTPUT_LENGTH) ? {8'h00, out_len_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_len_r <= '0;
    end else begin
      out_len_r <= out_len_nxt;
    end
  end

  // Hold input while the copy engine is busy; drop input once the stream is finished
  assign in_stall = busy;
  assign halted   = (produced >= out_len_r);
  assign in_take  = in_valid && !in_stall && !halted;

  lzsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_take),
    .in_byte (in_byte),
    .cmd     (cmd)
  );

  lzsd_copy_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .output_length   (out_len_r),
    .busy            (busy),
    .produced        (produced),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

endmodule

>>> bench/lzsd_decode_checker.sv
`timescale 1ns / 1ps

module lzsd_decode_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_run_last,
  input  logic        out_stream_done,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  import lzsd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_done;
  } dec_byte_t;

  // Expected decompressed bytes, oldest first
  dec_byte_t         exp_bytes[$];

  // Own copy of the decoder state
  logic [7:0]        dict[WinDepth];
  logic [WinAw-1:0]  wr_ptr;
  logic [15:0]       flag_bits;
  phase_t            phase;
  logic [7:0]        ref_low;
  logic [CountW-1:0] produced;
  logic [CountW-1:0] target_len;
  int                errors = 0;

  assign fail_count = errors;

  task automatic report(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Store one byte in the dictionary and queue it as expected output
  task automatic emit_byte(input logic [7:0] c);
    dec_byte_t e;
    dict[wr_ptr] = c;
    wr_ptr = wr_ptr + 1'b1;
    produced = produced + 1'b1;
    e.data = c;
    e.run_last = 1'b0;
    e.stream_done = (produced == target_len);
    exp_bytes.push_back(e);
  endtask

  // Drop the used flag bit; the marker bit says whether tokens remain
  task automatic close_token();
    flag_bits = flag_bits >> 1;
    phase = flag_bits[8] ? PH_LOW : PH_FLAG;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [15:0]      ref_word;
    logic [WinAw-1:0] rd_pos;
    logic [LenW-1:0]  remain;
    int               n;
    dec_byte_t        e;
    n = 0;
    // Finished stream: ignore everything
    if (produced >= target_len) return;
    case (phase)
      PH_LOW: begin
        if (flag_bits[0]) begin
          emit_byte(b);
          n = 1;
          close_token();
        end else begin
          ref_low = b;
          phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        ref_word = {b, ref_low};
        rd_pos = ref_word[WinAw-1:0];
        remain = LenW'(ref_word[15:12]) + MinMatch;
        // Copy byte by byte so overlapping copies see fresh data; stop at the length
        while (remain != 0 && produced < target_len) begin
          emit_byte(dict[rd_pos]);
          n++;
          rd_pos = rd_pos + 1'b1;
          remain = remain - 1'b1;
        end
        close_token();
      end
      default: begin
        flag_bits = {8'hFF, b};
        phase = PH_LOW;
      end
    endcase
    // Mark the last byte of this transfer's run
    if (n > 0) begin
      e = exp_bytes.pop_back();
      e.run_last = 1'b1;
      exp_bytes.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    dec_byte_t want;
    if (!rst_n) begin
      exp_bytes.delete();
      foreach (dict[i]) dict[i] = 8'h00;
      wr_ptr = WinStart;
      flag_bits = '0;
      phase = PH_FLAG;
      ref_low = '0;
      produced = '0;
      target_len = '0;
    end else begin
      // Follow register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_OUTPUT_LENGTH) begin
        target_len = cfg_pwdata[CountW-1:0];
      end
      // Compare each output transfer with the oldest expected byte
      if (out_valid && !out_stall) begin
        if (exp_bytes.size() == 0) begin
          report($sformatf("unexpected byte %02h last %0b done %0b",
                           out_byte, out_run_last, out_stream_done));
        end else begin
          want = exp_bytes.pop_front();
          if (out_byte !== want.data || out_run_last !== want.run_last ||
              out_stream_done !== want.stream_done) begin
            report($sformatf("byte exp %02h got %02h, last exp %0b got %0b, done exp %0b got %0b",
                             want.data, out_byte, want.run_last, out_run_last,
                             want.stream_done, out_stream_done));
          end
        end
      end
      // Predict from each input transfer
      if (in_valid && !in_stall) decode_byte(in_byte);
    end
    pending <= exp_bytes.size();
  end

endmodule

>>> bench/tb_lzss_stream_decoder.sv
`timescale 1ns / 1ps

module tb_lzss_stream_decoder;
  import lzsd_pkg::*;

  localparam int DrainCycles = 30;
  localparam int QuietLimit  = 3000;
  localparam int RandomBytes = 110;
  localparam int TailBytes   = 30;

  localparam logic [2:0] AddrOutLen = {REG_OUTPUT_LENGTH, 2'b00};
  localparam logic [2:0] AddrSpare  = 3'd4;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              out_run_last;
  logic              out_stream_done;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [2:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                pending;

  logic              no_idle = 1'b0;
  int                quiet_cycles = 0;
  int                in_seen = 0;
  logic [CountW-1:0] out_seen = '0;

  // Stimulus side view of the token stream, used to shape well-formed input
  phase_t            g_phase = PH_FLAG;
  logic [7:0]        g_flags = '0;
  int                g_left = 0;
  logic [WinAw-1:0]  g_wptr = WinStart;
  logic [7:0]        g_hi = '0;

  lzss_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_done(out_stream_done),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  lzsd_decode_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_stream_done(out_stream_done),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random back-pressure on the output
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 38);
  end

  // Count transfers and stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) in_seen <= in_seen + 1;
    if (rst_n && out_valid && !out_stall) out_seen <= out_seen + 1'b1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d bytes still expected",
               quiet_cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic drive_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic next_gen_token();
    g_flags = g_flags >> 1;
    g_left--;
    g_phase = (g_left > 0) ? PH_LOW : PH_FLAG;
  endtask

  // Advance the stimulus view of the parser by one byte
  task automatic track_byte(input logic [7:0] b);
    case (g_phase)
      PH_LOW: begin
        if (g_flags[0]) begin
          g_wptr = g_wptr + 1'b1;
          next_gen_token();
        end else begin
          g_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        g_wptr = g_wptr + WinAw'(b[7:4]) + WinAw'(MinMatch);
        next_gen_token();
      end
      default: begin
        g_flags = b;
        g_left = 8;
        g_phase = PH_LOW;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    drive_byte(b);
    track_byte(b);
  endtask

  // Mostly well-formed tokens with random content, some plain noise bytes
  task automatic send_stream_byte();
    logic [7:0]       b;
    logic [WinAw-1:0] pos;
    logic [3:0]       len_code;
    b = 8'($urandom);
    if ($urandom_range(99) >= 10) begin
      case (g_phase)
        PH_LOW: begin
          if (!g_flags[0]) begin
            len_code = 4'($urandom);
            // Short distances give overlapping copies
            if ($urandom_range(99) < 70) begin
              pos = g_wptr - WinAw'($urandom_range(20, 1));
            end else begin
              pos = WinAw'($urandom);
            end
            b = pos[7:0];
            g_hi = {len_code, pos[11:8]};
          end
        end
        PH_HIGH: b = g_hi;
        default: ;
      endcase
    end
    send_byte(b);
  endtask

  // Drop valid, let expected bytes drain, then let in-flight work settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    g_wptr = WinStart + out_seen[WinAw-1:0];
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    // Flag 0x23: literals 00 and FF, overlapping copy across the window end,
    // copy of never-written entries, wrapped read, literal, then a copy cut short
    logic [7:0] directed[12] = '{8'h23, 8'h00, 8'hFF, 8'hEF, 8'hFF, 8'h00,
                                 8'h08, 8'hFF, 8'h1F, 8'hA5, 8'hEE, 8'h7F};
    int n;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero output length: input is dropped
    cfg_write(AddrOutLen, 32'd0);
    drive_byte(8'h00);
    drive_byte(8'hFF);
    wait_idle();

    cfg_write(AddrOutLen, 32'd32);
    foreach (directed[i]) send_byte(directed[i]);
    // Length reached: these are dropped
    drive_byte(8'h5A);
    drive_byte(8'h3C);
    wait_idle();

    // Length lowered below the count already produced
    cfg_write(AddrOutLen, 32'd5);
    drive_byte(8'h11);
    wait_idle();

    // Write to an unused index must not move the length
    cfg_write(AddrSpare, 32'h00FF_FFFF);
    drive_byte(8'h22);
    wait_idle();

    // Largest length; finish the pending reference with the longest copy
    cfg_write(AddrOutLen, 32'h00FF_FFFF);
    send_byte(8'h00);
    send_byte(8'hF0);

    for (n = 0; n < RandomBytes; n++) begin
      no_idle <= (n >= 60 && n < 100);
      send_stream_byte();
    end
    wait_idle();

    // End the stream part way through the tail; later input is dropped
    cfg_write(AddrOutLen, 32'(out_seen + 24'd20));
    for (n = 0; n < TailBytes; n++) send_stream_byte();
    wait_idle();

    $display("%0d compressed bytes in, %0d bytes out, over several length settings",
             in_seen, out_seen);
    $display("covered literals, overlapping and wrapped copies, cut copies, dropped input");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/lzsd_pkg.sv
hw/rtl/lzsd_window_ram.sv
hw/rtl/lzsd_parser.sv
hw/rtl/lzsd_copy_engine.sv
hw/rtl/lzss_stream_decoder.sv
bench/lzsd_decode_checker.sv
bench/tb_lzss_stream_decoder.sv
